/* sv/byte_stuffed_frame_decoder_macros.svh */
// Assertion macros for the frame decoder.
`ifndef BYTE_STUFFED_FRAME_DECODER_MACROS_SVH
`define BYTE_STUFFED_FRAME_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSFD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

/* sv/bsfd_pkg.sv */
`timescale 1ns / 1ps

package bsfd_pkg;

  localparam int unsigned LEN_W = 15;

  localparam logic [7:0] CH_DELIM     = 8'h41;
  localparam logic [7:0] CH_ESC       = 8'h42;
  localparam logic [7:0] CH_ESC_DELIM = 8'h43;
  localparam logic [7:0] CH_ESC_ESC   = 8'h44;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 15'd1024;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_END      = 3'd2,
    KIND_BAD_ESC  = 3'd3,
    KIND_OVERFLOW = 3'd4,
    KIND_FAULT    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FRAME,
    ST_ESC
  } dec_state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_fault;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] frame_length;
    logic             frame_last;
  } result_t;

endpackage

/* sv/bsfd_in_reg.sv */
`timescale 1ns / 1ps

module bsfd_in_reg
  import bsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.rx_byte  <= in_tdata;
      item_r.rx_fault <= in_tuser;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* sv/bsfd_decode.sv */
`timescale 1ns / 1ps

module bsfd_decode
  import bsfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             step,
  input  item_t            item,
  output result_t          res
);

  dec_state_t       state_r;
  dec_state_t       state_nxt;
  logic [LEN_W-1:0] count_r;
  logic [LEN_W-1:0] count_nxt;
  logic [LEN_W-1:0] max_len_r;
  logic [LEN_W:0]   count_inc;
  logic             ovf;
  logic             is_delim;

  assign count_inc = {1'b0, count_r} + {{LEN_W{1'b0}}, 1'b1};
  assign ovf       = count_inc >= {1'b0, max_len_r};
  assign is_delim  = item.rx_byte == CH_DELIM;

  always_comb begin
    state_nxt = state_r;
    if (item.rx_fault) begin
      state_nxt = ST_HUNT;
    end else begin
      unique case (state_r)
        ST_HUNT: begin
          if (is_delim) begin
            state_nxt = ST_FRAME;
          end
        end
        ST_FRAME: begin
          if (is_delim) begin
            state_nxt = ST_HUNT;
          end else if (item.rx_byte == CH_ESC) begin
            state_nxt = ST_ESC;
          end else if (ovf) begin
            state_nxt = ST_HUNT;
          end
        end
        ST_ESC: begin
          if (!is_delim && !ovf &&
              (item.rx_byte == CH_ESC_DELIM || item.rx_byte == CH_ESC_ESC)) begin
            state_nxt = ST_FRAME;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  always_comb begin
    res.kind         = KIND_NONE;
    res.data_byte    = 8'h00;
    res.frame_length = '0;
    res.frame_last   = 1'b0;
    if (item.rx_fault) begin
      res.kind       = KIND_FAULT;
      res.frame_last = state_r != ST_HUNT;
    end else if (state_r != ST_HUNT && is_delim) begin
      res.kind         = KIND_END;
      res.frame_length = count_r;
      res.frame_last   = 1'b1;
    end else begin
      unique case (state_r)
        ST_HUNT: res.kind = KIND_NONE;
        ST_FRAME: begin
          if (item.rx_byte == CH_ESC) begin
            res.kind = KIND_NONE;
          end else if (ovf) begin
            res.kind       = KIND_OVERFLOW;
            res.frame_last = 1'b1;
          end else begin
            res.kind      = KIND_DATA;
            res.data_byte = item.rx_byte;
          end
        end
        ST_ESC: begin
          if (item.rx_byte != CH_ESC_DELIM && item.rx_byte != CH_ESC_ESC) begin
            res.kind       = KIND_BAD_ESC;
            res.frame_last = 1'b1;
          end else if (ovf) begin
            res.kind       = KIND_OVERFLOW;
            res.frame_last = 1'b1;
          end else begin
            res.kind      = KIND_DATA;
            res.data_byte = (item.rx_byte == CH_ESC_DELIM) ? CH_DELIM : CH_ESC;
          end
        end
        default: res.kind = KIND_NONE;
      endcase
    end
  end

  assign count_nxt = (state_nxt == ST_HUNT) ? '0 :
                     (res.kind == KIND_DATA) ? count_inc[LEN_W-1:0] : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_HUNT;
      count_r   <= '0;
      max_len_r <= MAX_LEN_RST;
    end else begin
      if (step) begin
        state_r <= state_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

endmodule

/* sv/bsfd_out_reg.sv */
`timescale 1ns / 1ps

module bsfd_out_reg
  import bsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        advance,
  input  logic        item_valid,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign advance   = item_valid && (!valid_r || out_tready);
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, res_r.frame_length, res_r.data_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.frame_last;

endmodule

/* sv/byte_stuffed_frame_decoder.sv */
`timescale 1ns / 1ps
// Receive-side decoder for a byte-stuffed serial frame format.
// Input stream: in_tdata carries one received byte, in_tuser marks a line
// fault (read error or timeout) in place of a byte. Each input transfer
// gives exactly one output transfer: out_tuser holds the result kind,
// out_tdata the decoded byte and the frame length, out_tlast marks the
// result that ends or aborts a frame.
// Configuration: cfg_we writes cfg_wdata into the maximum frame length;
// it should only be written while no transfer is in flight.
// After an input transfer, the byte is held in the input register, then
// the decode logic feeds its result into the output register, which
// raises out_tvalid.
// Throughput is one transfer per cycle while out_tready stays high; the
// decode of a byte and the next frame state are combinational logic.
// When the receiver holds out_tready low, the output register keeps its
// result, the input register fills, and in_tready then drops until the
// output is taken; nothing is lost or repeated.
// Reset (rst_n low on a clock edge) empties both registers, returns the
// decoder to hunting for a delimiter and sets the maximum length to 1024.
module byte_stuffed_frame_decoder
  import bsfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tuser,   // [0] rx_fault
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // [7:0] data_byte, [22:8] frame_length
  output logic [2:0]       out_tuser,  // [2:0] kind
  output logic             out_tlast
);

  logic    advance;
  logic    item_valid;
  item_t   item;
  result_t res;
  logic    out_abort;

  bsfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bsfd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item),
    .res       (res)
  );

  bsfd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .advance    (advance),
    .item_valid (item_valid),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_abort = out_tuser == KIND_END || out_tuser == KIND_BAD_ESC ||
                     out_tuser == KIND_OVERFLOW;

`include "byte_stuffed_frame_decoder_macros.svh"

  `BSFD_ASSERT_IMP(a_last_kind, out_tvalid && out_tlast, out_abort || out_tuser == KIND_FAULT)
  `BSFD_ASSERT_IMP(a_abort_last, out_tvalid && out_abort, out_tlast)
  `BSFD_ASSERT_IMP(a_data_zero, out_tvalid && out_tuser != KIND_DATA, out_tdata[7:0] == 8'h00)
  `BSFD_ASSERT_IMP(a_ready_stall, !in_tready, out_tvalid && !out_tready)
  `BSFD_ASSERT_NXT(a_load_valid, advance, out_tvalid)

endmodule
